// ===== hw/rtl/mqps_pkg.sv =====
package mqps_pkg;

   localparam int NUM_QUEUES   = 5;
   localparam int NUM_LEVELS   = 3;
   localparam int POOL_ENTRIES = 64;
   localparam int TAG_BITS     = 16;
   localparam int ITEM_BITS    = 16;

   localparam int QUEUE_BITS     = 3;
   localparam int PRIO_BITS      = 2;
   localparam int OPCODE_BITS    = 2;
   localparam int STATUS_BITS    = 4;
   localparam int NUM_LISTS      = NUM_QUEUES * NUM_LEVELS;
   localparam int LIST_BITS      = $clog2(NUM_LISTS);
   localparam int SLOT_BITS      = $clog2(POOL_ENTRIES);
   localparam int COUNT_BITS     = $clog2(POOL_ENTRIES + 1);
   localparam int LEVEL_CNT_BITS = $clog2(NUM_LEVELS + 1);
   localparam int OPEN_CNT_BITS  = $clog2(NUM_QUEUES + 1);

   localparam int REQ_FIELD_BITS = QUEUE_BITS + PRIO_BITS + TAG_BITS + ITEM_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = TAG_BITS + PRIO_BITS + ITEM_BITS + QUEUE_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_SERVE   = 2'd1,
      OP_CLOSE   = 2'd2
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_QUEUED         = 4'd0,
      STAT_DROPPED        = 4'd1,
      STAT_POOL_FULL      = 4'd2,
      STAT_SERVED         = 4'd3,
      STAT_EMPTY          = 4'd4,
      STAT_ALREADY_CLOSED = 4'd5,
      STAT_LAST_OPEN_BUSY = 4'd6,
      STAT_NO_OTHER_OPEN  = 4'd7,
      STAT_MOVED          = 4'd8
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ENQ_WR,
      S_SRV_RD,
      S_SRV_WR,
      S_CLS_SRC,
      S_CLS_DST,
      S_CLS_WR,
      S_FIN
   } state_type;

   // Request fields, last field in the lowest bits.
   typedef struct packed {
      logic [ITEM_BITS-1:0]  item_count;
      logic [TAG_BITS-1:0]   customer_tag;
      logic [PRIO_BITS-1:0]  priority_req;
      logic [QUEUE_BITS-1:0] queue_index;
   } req_data_type;

   typedef struct packed {
      logic [QUEUE_BITS-1:0] target_queue;
      logic [ITEM_BITS-1:0]  served_items;
      logic [PRIO_BITS-1:0]  served_priority;
      logic [TAG_BITS-1:0]   served_tag;
   } rsp_data_type;

   typedef struct packed {
      status_type   status;
      rsp_data_type data;
   } rsp_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0] head;
      logic [SLOT_BITS-1:0] tail;
   } ptr_word_type;

   typedef struct packed {
      logic [LIST_BITS-1:0] raddr;
      logic                 we;
      logic [LIST_BITS-1:0] waddr;
      ptr_word_type         wdata;
   } ptr_req_type;

   typedef struct packed {
      logic [TAG_BITS-1:0]  tag;
      logic [ITEM_BITS-1:0] items;
   } entry_word_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0] raddr;
      logic                 dwe;
      logic [SLOT_BITS-1:0] daddr;
      entry_word_type       dwdata;
      logic                 lwe;
      logic [SLOT_BITS-1:0] laddr;
      logic [SLOT_BITS-1:0] lwdata;
   } entry_req_type;

   typedef struct packed {
      entry_word_type       data;
      logic [SLOT_BITS-1:0] link;
   } entry_rd_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0] raddr;
      logic                 we;
      logic [SLOT_BITS-1:0] waddr;
      logic [SLOT_BITS-1:0] wdata;
   } fs_req_type;

endpackage

// ===== hw/rtl/mqps_ptr_mem.sv =====
module mqps_ptr_mem (
   input  logic                  clock,
   input  mqps_pkg::ptr_req_type ptr_req,
   output mqps_pkg::ptr_word_type ptr_rdata
);

   mqps_pkg::ptr_word_type mem [mqps_pkg::NUM_LISTS];
   mqps_pkg::ptr_word_type rdata_ff;

   always_ff @(posedge clock) begin
      if (ptr_req.we) begin
         mem[ptr_req.waddr] <= ptr_req.wdata;
      end
      rdata_ff <= mem[ptr_req.raddr];
   end

   assign ptr_rdata = rdata_ff;

endmodule

// ===== hw/rtl/mqps_entry_mem.sv =====
module mqps_entry_mem (
   input  logic                    clock,
   input  mqps_pkg::entry_req_type ent_req,
   output mqps_pkg::entry_rd_type  ent_rdata
);

   mqps_pkg::entry_word_type      data_mem [mqps_pkg::POOL_ENTRIES];
   logic [mqps_pkg::SLOT_BITS-1:0] link_mem [mqps_pkg::POOL_ENTRIES];
   mqps_pkg::entry_rd_type        rdata_ff;

   always_ff @(posedge clock) begin
      if (ent_req.dwe) begin
         data_mem[ent_req.daddr] <= ent_req.dwdata;
      end
      if (ent_req.lwe) begin
         link_mem[ent_req.laddr] <= ent_req.lwdata;
      end
      rdata_ff.data <= data_mem[ent_req.raddr];
      rdata_ff.link <= link_mem[ent_req.raddr];
   end

   assign ent_rdata = rdata_ff;

endmodule

// ===== hw/rtl/mqps_free_stack.sv =====
module mqps_free_stack (
   input  logic                           clock,
   input  logic                           reset,
   input  mqps_pkg::fs_req_type           fs_req,
   output logic [mqps_pkg::SLOT_BITS-1:0] fs_rdata
);

   logic [mqps_pkg::SLOT_BITS-1:0]    mem [mqps_pkg::POOL_ENTRIES];
   logic [mqps_pkg::POOL_ENTRIES-1:0] written_ff;
   logic [mqps_pkg::SLOT_BITS-1:0]    rdata_ff;
   logic [mqps_pkg::SLOT_BITS-1:0]    raddr_ff;
   logic                              rwritten_ff;

   // An entry never pushed reads as its own index.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (fs_req.we) begin
         written_ff[fs_req.waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fs_req.we) begin
         mem[fs_req.waddr] <= fs_req.wdata;
      end
      rdata_ff    <= mem[fs_req.raddr];
      raddr_ff    <= fs_req.raddr;
      rwritten_ff <= written_ff[fs_req.raddr];
   end

   assign fs_rdata = rwritten_ff ? rdata_ff : raddr_ff;

endmodule

// ===== hw/rtl/mqps_ctrl.sv =====
module mqps_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [mqps_pkg::OPCODE_BITS-1:0] req_opcode,
   input  mqps_pkg::req_data_type           req_data,
   output logic                             res_valid,
   input  logic                             res_ready,
   output mqps_pkg::rsp_type                res,
   output mqps_pkg::ptr_req_type            ptr_req,
   input  mqps_pkg::ptr_word_type           ptr_rdata,
   output mqps_pkg::entry_req_type          ent_req,
   input  mqps_pkg::entry_rd_type           ent_rdata,
   output mqps_pkg::fs_req_type             fs_req,
   input  logic [mqps_pkg::SLOT_BITS-1:0]   fs_rdata
);

   function automatic logic [mqps_pkg::LIST_BITS-1:0] list_index(
      input logic [mqps_pkg::QUEUE_BITS-1:0]     queue,
      input logic [mqps_pkg::LEVEL_CNT_BITS-1:0] level
   );
      return mqps_pkg::LIST_BITS'(int'(queue) * mqps_pkg::NUM_LEVELS + int'(level));
   endfunction

   mqps_pkg::state_type state_ff, state_in;

   logic [mqps_pkg::NUM_QUEUES-1:0]     open_ff, open_in;
   logic [mqps_pkg::NUM_LISTS-1:0]      nonempty_ff, nonempty_in;
   logic [mqps_pkg::COUNT_BITS-1:0]     free_count_ff, free_count_in;
   logic [mqps_pkg::QUEUE_BITS-1:0]     q_ff, q_in;
   logic [mqps_pkg::QUEUE_BITS-1:0]     tgt_ff, tgt_in;
   logic [mqps_pkg::LIST_BITS-1:0]      li_ff, li_in;
   logic [mqps_pkg::LEVEL_CNT_BITS-1:0] lvl_ff, lvl_in;
   logic [mqps_pkg::TAG_BITS-1:0]       tag_ff, tag_in;
   logic [mqps_pkg::ITEM_BITS-1:0]      items_ff, items_in;
   mqps_pkg::ptr_word_type              ptr_ff, ptr_in;
   mqps_pkg::rsp_type                   res_ff, res_in;

   logic                                accept;
   logic                                q_valid;
   logic                                q_open;
   logic [mqps_pkg::NUM_LEVELS-1:0]     q_lists;
   logic [mqps_pkg::NUM_LEVELS-1:0]     held_q_lists;
   logic                                srv_found;
   logic [mqps_pkg::LEVEL_CNT_BITS-1:0] srv_lvl;
   logic [mqps_pkg::LEVEL_CNT_BITS-1:0] enq_lvl;
   logic [mqps_pkg::OPEN_CNT_BITS-1:0]  open_n;
   logic                                tgt_found;
   logic [mqps_pkg::QUEUE_BITS-1:0]     tgt_sel;
   logic                                any_entry;
   mqps_pkg::state_type                 idle_next;
   mqps_pkg::status_type                idle_status;
   logic [mqps_pkg::LIST_BITS-1:0]      src_li;
   logic [mqps_pkg::LIST_BITS-1:0]      dst_li;
   logic                                levels_done;

   assign req_ready    = (state_ff == mqps_pkg::S_IDLE);
   assign accept       = req_valid && req_ready;
   assign res_valid    = (state_ff == mqps_pkg::S_FIN);
   assign res          = res_ff;
   assign src_li       = list_index(q_ff, lvl_ff);
   assign dst_li       = list_index(tgt_ff, lvl_ff);
   assign levels_done  = (int'(lvl_ff) == mqps_pkg::NUM_LEVELS);
   assign held_q_lists = mqps_pkg::NUM_LEVELS'(nonempty_ff >> (int'(q_ff) * mqps_pkg::NUM_LEVELS));

   // Checks made on the request as it is accepted, all from flag and count registers.
   always_comb begin
      q_valid   = int'(req_data.queue_index) < mqps_pkg::NUM_QUEUES;
      q_open    = q_valid && open_ff[req_data.queue_index];
      q_lists   = mqps_pkg::NUM_LEVELS'(nonempty_ff >>
                  (int'(req_data.queue_index) * mqps_pkg::NUM_LEVELS));
      any_entry = |nonempty_ff;

      srv_found = 1'b0;
      srv_lvl   = '0;
      for (int l = mqps_pkg::NUM_LEVELS - 1; l >= 0; l--) begin
         if (q_lists[l]) begin
            srv_found = 1'b1;
            srv_lvl   = mqps_pkg::LEVEL_CNT_BITS'(l);
         end
      end

      // Out-of-range levels are clamped to the nearest valid one.
      if (req_data.priority_req == '0) begin
         enq_lvl = '0;
      end else if (int'(req_data.priority_req) > mqps_pkg::NUM_LEVELS) begin
         enq_lvl = mqps_pkg::LEVEL_CNT_BITS'(mqps_pkg::NUM_LEVELS - 1);
      end else begin
         enq_lvl = mqps_pkg::LEVEL_CNT_BITS'(int'(req_data.priority_req) - 1);
      end

      open_n    = '0;
      tgt_found = 1'b0;
      tgt_sel   = '0;
      for (int i = mqps_pkg::NUM_QUEUES - 1; i >= 0; i--) begin
         if (open_ff[i]) begin
            open_n = open_n + 1'b1;
            if (mqps_pkg::QUEUE_BITS'(i) != req_data.queue_index) begin
               tgt_found = 1'b1;
               tgt_sel   = mqps_pkg::QUEUE_BITS'(i);
            end
         end
      end

      idle_next   = mqps_pkg::S_FIN;
      idle_status = mqps_pkg::STAT_QUEUED;
      unique case (req_opcode)
         mqps_pkg::OP_ENQUEUE: begin
            if (!q_open) begin
               idle_status = mqps_pkg::STAT_DROPPED;
            end else if (free_count_ff == '0) begin
               idle_status = mqps_pkg::STAT_POOL_FULL;
            end else begin
               idle_next = mqps_pkg::S_ENQ_WR;
            end
         end
         mqps_pkg::OP_SERVE: begin
            if (q_valid && srv_found) begin
               idle_next = mqps_pkg::S_SRV_RD;
            end else begin
               idle_status = mqps_pkg::STAT_EMPTY;
            end
         end
         mqps_pkg::OP_CLOSE: begin
            if (!q_open) begin
               idle_status = mqps_pkg::STAT_ALREADY_CLOSED;
            end else if (any_entry && open_n == mqps_pkg::OPEN_CNT_BITS'(1)) begin
               idle_status = mqps_pkg::STAT_LAST_OPEN_BUSY;
            end else if (!tgt_found) begin
               idle_status = mqps_pkg::STAT_NO_OTHER_OPEN;
            end else begin
               idle_next = mqps_pkg::S_CLS_SRC;
            end
         end
         default: begin
            // The unused opcode is swallowed without a result.
            idle_next = mqps_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mqps_pkg::S_IDLE: begin
            if (accept) begin
               state_in = idle_next;
            end
         end
         mqps_pkg::S_ENQ_WR: state_in = mqps_pkg::S_FIN;
         mqps_pkg::S_SRV_RD: state_in = mqps_pkg::S_SRV_WR;
         mqps_pkg::S_SRV_WR: state_in = mqps_pkg::S_FIN;
         mqps_pkg::S_CLS_SRC: begin
            if (levels_done) begin
               state_in = mqps_pkg::S_FIN;
            end else if (nonempty_ff[src_li]) begin
               state_in = mqps_pkg::S_CLS_DST;
            end
         end
         mqps_pkg::S_CLS_DST: state_in = mqps_pkg::S_CLS_WR;
         mqps_pkg::S_CLS_WR:  state_in = mqps_pkg::S_CLS_SRC;
         mqps_pkg::S_FIN: begin
            if (res_ready) begin
               state_in = mqps_pkg::S_IDLE;
            end
         end
         default: state_in = mqps_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      open_in       = open_ff;
      nonempty_in   = nonempty_ff;
      free_count_in = free_count_ff;
      q_in          = q_ff;
      tgt_in        = tgt_ff;
      li_in         = li_ff;
      lvl_in        = lvl_ff;
      tag_in        = tag_ff;
      items_in      = items_ff;
      ptr_in        = ptr_ff;
      res_in        = res_ff;
      ptr_req       = '0;
      ent_req       = '0;
      fs_req        = '0;

      unique case (state_ff)
         mqps_pkg::S_IDLE: begin
            if (accept) begin
               q_in          = req_data.queue_index;
               tag_in        = req_data.customer_tag;
               items_in      = req_data.item_count;
               tgt_in        = tgt_sel;
               res_in        = '0;
               res_in.status = idle_status;
               if (req_opcode == mqps_pkg::OP_SERVE) begin
                  lvl_in = srv_lvl;
                  li_in  = list_index(req_data.queue_index, srv_lvl);
               end else if (req_opcode == mqps_pkg::OP_CLOSE) begin
                  lvl_in = '0;
               end else begin
                  lvl_in = enq_lvl;
                  li_in  = list_index(req_data.queue_index, enq_lvl);
               end
               if (idle_next == mqps_pkg::S_ENQ_WR) begin
                  fs_req.raddr  = mqps_pkg::SLOT_BITS'(free_count_ff - 1'b1);
                  ptr_req.raddr = list_index(req_data.queue_index, enq_lvl);
               end else if (idle_next == mqps_pkg::S_SRV_RD) begin
                  ptr_req.raddr = list_index(req_data.queue_index, srv_lvl);
               end
            end
         end
         mqps_pkg::S_ENQ_WR: begin
            ent_req.dwe          = 1'b1;
            ent_req.daddr        = fs_rdata;
            ent_req.dwdata.tag   = tag_ff;
            ent_req.dwdata.items = items_ff;
            ptr_req.we           = 1'b1;
            ptr_req.waddr        = li_ff;
            ptr_req.wdata.tail   = fs_rdata;
            if (nonempty_ff[li_ff]) begin
               ent_req.lwe        = 1'b1;
               ent_req.laddr      = ptr_rdata.tail;
               ent_req.lwdata     = fs_rdata;
               ptr_req.wdata.head = ptr_rdata.head;
            end else begin
               ptr_req.wdata.head = fs_rdata;
            end
            nonempty_in[li_ff] = 1'b1;
            free_count_in      = free_count_ff - 1'b1;
         end
         mqps_pkg::S_SRV_RD: begin
            ptr_in        = ptr_rdata;
            ent_req.raddr = ptr_rdata.head;
         end
         mqps_pkg::S_SRV_WR: begin
            if (ptr_ff.head == ptr_ff.tail) begin
               nonempty_in[li_ff] = 1'b0;
            end else begin
               ptr_req.we         = 1'b1;
               ptr_req.waddr      = li_ff;
               ptr_req.wdata.head = ent_rdata.link;
               ptr_req.wdata.tail = ptr_ff.tail;
            end
            if (int'(free_count_ff) < mqps_pkg::POOL_ENTRIES) begin
               fs_req.we     = 1'b1;
               fs_req.waddr  = mqps_pkg::SLOT_BITS'(free_count_ff);
               fs_req.wdata  = ptr_ff.head;
               free_count_in = free_count_ff + 1'b1;
            end
            res_in.data.served_tag      = ent_rdata.data.tag;
            res_in.data.served_items    = ent_rdata.data.items;
            res_in.data.served_priority = mqps_pkg::PRIO_BITS'(int'(lvl_ff) + 1);
            res_in.status               = mqps_pkg::STAT_SERVED;
         end
         mqps_pkg::S_CLS_SRC: begin
            if (levels_done) begin
               open_in[q_ff]            = 1'b0;
               res_in.status            = mqps_pkg::STAT_MOVED;
               res_in.data.target_queue = tgt_ff;
            end else if (nonempty_ff[src_li]) begin
               ptr_req.raddr = src_li;
            end else begin
               lvl_in = lvl_ff + 1'b1;
            end
         end
         mqps_pkg::S_CLS_DST: begin
            ptr_in        = ptr_rdata;
            ptr_req.raddr = dst_li;
         end
         mqps_pkg::S_CLS_WR: begin
            // Splice the source list behind the receiving list of the same level.
            ptr_req.we    = 1'b1;
            ptr_req.waddr = dst_li;
            if (nonempty_ff[dst_li]) begin
               ent_req.lwe        = 1'b1;
               ent_req.laddr      = ptr_rdata.tail;
               ent_req.lwdata     = ptr_ff.head;
               ptr_req.wdata.head = ptr_rdata.head;
               ptr_req.wdata.tail = ptr_ff.tail;
            end else begin
               ptr_req.wdata = ptr_ff;
            end
            nonempty_in[dst_li] = 1'b1;
            nonempty_in[src_li] = 1'b0;
            lvl_in              = lvl_ff + 1'b1;
         end
         mqps_pkg::S_FIN: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mqps_pkg::S_IDLE;
         open_ff       <= '1;
         nonempty_ff   <= '0;
         free_count_ff <= mqps_pkg::COUNT_BITS'(mqps_pkg::POOL_ENTRIES);
      end else begin
         state_ff      <= state_in;
         open_ff       <= open_in;
         nonempty_ff   <= nonempty_in;
         free_count_ff <= free_count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff     <= q_in;
      tgt_ff   <= tgt_in;
      li_ff    <= li_in;
      lvl_ff   <= lvl_in;
      tag_ff   <= tag_in;
      items_ff <= items_in;
      ptr_ff   <= ptr_in;
      res_ff   <= res_in;
   end

   a_enqueue_links: assert property (@(posedge clock) disable iff (reset)
      state_ff == mqps_pkg::S_ENQ_WR |=>
         nonempty_ff[li_ff] &&
         free_count_ff == mqps_pkg::COUNT_BITS'($past(free_count_ff) - 1'b1))
      else $error("enqueue did not take a slot and fill its list");

   a_closed_stays_closed: assert property (@(posedge clock) disable iff (reset)
      (open_ff & ~$past(open_ff)) == '0)
      else $error("a closed queue was reopened");

   a_close_moves_all: assert property (@(posedge clock) disable iff (reset)
      state_ff == mqps_pkg::S_CLS_SRC && levels_done |=>
         held_q_lists == '0 && open_ff[tgt_ff] && !open_ff[q_ff])
      else $error("close left entries behind or closed the wrong queue");

endmodule

// ===== hw/rtl/multi_queue_priority_scheduler_unit.sv =====
// Bank of five priority queues sharing a pool of 64 entry slots.
// Requests arrive on the req_ stream: tuser carries the opcode (enqueue,
// serve or close) and tdata the queue, priority, tag and item count.
// Every request other than the unused opcode gives one result item on the
// rsp_ stream: tuser carries the status, tdata the served entry and the
// receiving queue of a successful close.
// One request is worked on at a time by a sequencer around three small
// synchronous memories (list pointers, entry payload and links, free stack),
// each with a registered read. A rejected request goes straight to its
// result; an enqueue writes the entry, its link and the list pointers; a
// serve reads the list head, then its entry, and frees the slot; a close
// makes a read-then-write pass over the pointer memory for each priority
// level that holds entries. Reset opens every queue, empties every list and
// fills the free stack; there is no clearing pass, so requests are taken as
// soon as reset is released. The result sits in an output register: while
// the receiver holds rsp_tready low the next request is still accepted and
// worked on, and it waits in its last step until the register is free.
module multi_queue_priority_scheduler_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // queue_index, priority_req, customer_tag, item_count, zero fill
   input  logic [mqps_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // opcode
   input  logic [mqps_pkg::OPCODE_BITS-1:0]    req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // served_tag, served_priority, served_items, target_queue, zero fill
   output logic [mqps_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   // status
   output logic [mqps_pkg::STATUS_BITS-1:0]    rsp_tuser
);

   mqps_pkg::req_data_type             req_data;
   mqps_pkg::rsp_type                  res;
   logic                               res_valid;
   logic                               res_ready;
   mqps_pkg::ptr_req_type              ptr_req;
   mqps_pkg::ptr_word_type             ptr_rdata;
   mqps_pkg::entry_req_type            ent_req;
   mqps_pkg::entry_rd_type             ent_rdata;
   mqps_pkg::fs_req_type               fs_req;
   logic [mqps_pkg::SLOT_BITS-1:0]     fs_rdata;
   logic                               rsp_valid_ff, rsp_valid_in;
   mqps_pkg::rsp_type                  rsp_ff, rsp_in;

   assign req_data = mqps_pkg::req_data_type'(req_tdata[mqps_pkg::REQ_FIELD_BITS-1:0]);

   mqps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_opcode (req_tuser),
      .req_data   (req_data),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res),
      .ptr_req    (ptr_req),
      .ptr_rdata  (ptr_rdata),
      .ent_req    (ent_req),
      .ent_rdata  (ent_rdata),
      .fs_req     (fs_req),
      .fs_rdata   (fs_rdata)
   );

   mqps_ptr_mem u_ptr_mem (
      .clock     (clock),
      .ptr_req   (ptr_req),
      .ptr_rdata (ptr_rdata)
   );

   mqps_entry_mem u_entry_mem (
      .clock     (clock),
      .ent_req   (ent_req),
      .ent_rdata (ent_rdata)
   );

   mqps_free_stack u_free_stack (
      .clock    (clock),
      .reset    (reset),
      .fs_req   (fs_req),
      .fs_rdata (fs_rdata)
   );

   // Output register: refilled when empty or when its item leaves this cycle.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = mqps_pkg::RSP_TDATA_BITS'(rsp_ff.data);
   assign rsp_tuser  = rsp_ff.status;

endmodule

// ===== tb/tb_multi_queue_priority_scheduler_unit.sv =====
module tb_multi_queue_priority_scheduler_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import mqps_pkg::*;

   localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;

   localparam int DIRECTED_ROWS   = 25;
   localparam int RANDOM_ITEMS    = 1100;
   localparam int DIRECTED_CLOSES = 2;
   localparam int HOLD_AFTER      = 300;
   localparam int HOLD_CYCLES     = 300;
   localparam int STALL_LIMIT     = 4000;
   localparam int SETTLE_CYCLES   = 24;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_type;
   typedef enum {PACE_OPEN, PACE_COIN, PACE_PERIODIC, PACE_SPARSE} pace_type;

   typedef struct {
      logic [OPCODE_BITS-1:0] opc;
      logic [QUEUE_BITS-1:0]  queue_index;
      logic [PRIO_BITS-1:0]   priority_req;
      logic [TAG_BITS-1:0]    customer_tag;
      logic [ITEM_BITS-1:0]   item_count;
      bit                     typed;
      status_type             want_status;
      logic [QUEUE_BITS-1:0]  want_queue;
   } plan_row_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata  = '0;
   logic [OPCODE_BITS-1:0]    req_tuser  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic [STATUS_BITS-1:0]    rsp_tuser;

   // Shadow of the scheduler state, kept in step with every accepted request.
   logic [NUM_QUEUES-1:0] queue_open;
   logic [NUM_LISTS-1:0]  level_filled;
   logic [SLOT_BITS-1:0]  level_head [NUM_LISTS];
   logic [SLOT_BITS-1:0]  level_tail [NUM_LISTS];
   logic [TAG_BITS-1:0]   slot_tag   [POOL_ENTRIES];
   logic [ITEM_BITS-1:0]  slot_items [POOL_ENTRIES];
   logic [SLOT_BITS-1:0]  slot_next  [POOL_ENTRIES];
   logic [SLOT_BITS-1:0]  free_slots [POOL_ENTRIES];
   int unsigned           free_slot_count;

   rsp_type      expected_results [$];
   plan_row_type directed_plan [DIRECTED_ROWS];
   int unsigned  requests_taken = 0;
   int unsigned  results_seen   = 0;
   int unsigned  mismatch_count = 0;
   int unsigned  burst_left     = 0;
   int unsigned  status_seen [16];

   multi_queue_priority_scheduler_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic bit predict_scheduler(input logic [OPCODE_BITS-1:0] opc,
                                            input req_data_type d, output rsp_type r);
      int unsigned qi, qn, lvl, li, dst, tgt, open_n, pr;
      logic [SLOT_BITS-1:0] e;
      bit q_ok;
      r = '0;
      qi = 32'(d.queue_index);
      pr = 32'(d.priority_req);
      q_ok = (qi < NUM_QUEUES) ? queue_open[qi] : 1'b0;
      case (opc)
         OP_ENQUEUE: begin
            if (!q_ok) begin
               r.status = STAT_DROPPED;
            end else if (free_slot_count == 0) begin
               r.status = STAT_POOL_FULL;
            end else begin
               // Priority 0 is treated as the top level.
               lvl = (pr == 0) ? 0 : (pr > NUM_LEVELS) ? NUM_LEVELS - 1 : pr - 1;
               free_slot_count--;
               e = free_slots[free_slot_count];
               slot_tag[e]   = d.customer_tag;
               slot_items[e] = d.item_count;
               slot_next[e]  = '0;
               li = qi * NUM_LEVELS + lvl;
               if (level_filled[li]) begin
                  slot_next[level_tail[li]] = e;
               end else begin
                  level_head[li]   = e;
                  level_filled[li] = 1'b1;
               end
               level_tail[li] = e;
               r.status = STAT_QUEUED;
            end
         end
         OP_SERVE: begin
            r.status = STAT_EMPTY;
            if (qi < NUM_QUEUES) begin
               for (lvl = 0; lvl < NUM_LEVELS; lvl++) begin
                  li = qi * NUM_LEVELS + lvl;
                  if (level_filled[li] && r.status == STAT_EMPTY) begin
                     e = level_head[li];
                     if (e == level_tail[li]) level_filled[li] = 1'b0;
                     else level_head[li] = slot_next[e];
                     if (free_slot_count < POOL_ENTRIES) begin
                        free_slots[free_slot_count] = e;
                        free_slot_count++;
                     end
                     r.status               = STAT_SERVED;
                     r.data.served_tag      = slot_tag[e];
                     r.data.served_priority = PRIO_BITS'(lvl + 1);
                     r.data.served_items    = slot_items[e];
                  end
               end
            end
         end
         OP_CLOSE: begin
            if (!q_ok) begin
               r.status = STAT_ALREADY_CLOSED;
            end else begin
               tgt = NUM_QUEUES;
               open_n = $countones(queue_open);
               for (qn = 0; qn < NUM_QUEUES; qn++)
                  if (queue_open[qn] && qn != qi && tgt == NUM_QUEUES) tgt = qn;
               if (level_filled != '0 && open_n == 1) begin
                  r.status = STAT_LAST_OPEN_BUSY;
               end else if (tgt == NUM_QUEUES) begin
                  r.status = STAT_NO_OTHER_OPEN;
               end else begin
                  // Each level list is spliced onto the tail of the same level.
                  for (lvl = 0; lvl < NUM_LEVELS; lvl++) begin
                     li  = qi * NUM_LEVELS + lvl;
                     dst = tgt * NUM_LEVELS + lvl;
                     if (level_filled[li]) begin
                        if (level_filled[dst]) begin
                           slot_next[level_tail[dst]] = level_head[li];
                        end else begin
                           level_head[dst]   = level_head[li];
                           level_filled[dst] = 1'b1;
                        end
                        level_tail[dst]  = level_tail[li];
                        level_filled[li] = 1'b0;
                     end
                  end
                  queue_open[qi]         = 1'b0;
                  r.status               = STAT_MOVED;
                  r.data.target_queue    = QUEUE_BITS'(tgt);
               end
            end
         end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   task automatic offer_request(input logic [OPCODE_BITS-1:0] opc, input req_data_type d,
                                input bit typed, input rsp_type typed_rsp);
      rsp_type predicted;
      int unsigned idle;
      req_tvalid <= 1'b1;
      req_tuser  <= opc;
      req_tdata  <= REQ_TDATA_BITS'(d);
      do @(posedge clock); while (!req_tready);
      requests_taken++;
      if (predict_scheduler(opc, d, predicted))
         expected_results.push_back(typed ? typed_rsp : predicted);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (idle != 0) begin
            req_tvalid <= 1'b0;
            repeat (idle) @(posedge clock);
         end
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      rsp_data_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_data_type'(rsp_tdata[RSP_FIELD_BITS-1:0]);
         results_seen++;
         if (!$isunknown(rsp_tuser)) status_seen[rsp_tuser]++;
         if (expected_results.size() == 0) begin
            $error("result item with no request waiting for it, status %0d", rsp_tuser);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("status", 16'(want.status), 16'(rsp_tuser));
            check_field("served_tag", want.data.served_tag, got.served_tag);
            check_field("served_priority", 16'(want.data.served_priority),
                        16'(got.served_priority));
            check_field("served_items", want.data.served_items, got.served_items);
            check_field("target_queue", 16'(want.data.target_queue),
                        16'(got.target_queue));
            check_field("tdata zero fill", '0,
                        16'(rsp_tdata[RSP_TDATA_BITS-1:RSP_FIELD_BITS]));
         end
      end
   end

   // The receiver changes its pacing in segments, and once holds off long
   // enough for the block to back up and refuse further requests.
   initial begin : rsp_pacing
      int unsigned seg_left, tick;
      pace_type pace;
      bit held;
      seg_left = 0;
      tick = 0;
      held = 1'b0;
      pace = PACE_OPEN;
      forever begin
         @(posedge clock);
         if (!held && requests_taken >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (seg_left == 0) begin
            pace = pace_type'($urandom_range(0, 3));
            seg_left = $urandom_range(8, 80);
         end
         seg_left--;
         tick++;
         case (pace)
            PACE_OPEN:     rsp_tready <= 1'b1;
            PACE_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
            PACE_PERIODIC: rsp_tready <= (tick % 4 != 0);
            default:       rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   initial begin : stall_watch
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("multi_queue_priority_scheduler_unit verification failed");
      $finish;
   end

   initial begin : stimulus
      int unsigned i, row, k, qi, roll, mix_left, allowed_closed;
      mix_type mix;
      logic [OPCODE_BITS-1:0] opc;
      req_data_type d;
      rsp_type want;

      queue_open      = '1;
      level_filled    = '0;
      free_slot_count = POOL_ENTRIES;
      for (i = 0; i < POOL_ENTRIES; i++) free_slots[i] = SLOT_BITS'(i);
      for (i = 0; i < 16; i++) status_seen[i] = 0;

      // Fields: opcode, queue, priority, tag, items, typed, status, target queue.
      directed_plan = '{
         '{OP_SERVE,   3'd0, 2'd1, 16'h0000, 16'h0000, 1'b1, STAT_EMPTY,          3'd0},
         '{OP_ENQUEUE, 3'd0, 2'd0, 16'hFFFF, 16'hFFFF, 1'b1, STAT_QUEUED,         3'd0},
         '{OP_ENQUEUE, 3'd0, 2'd3, 16'h0000, 16'h0000, 1'b1, STAT_QUEUED,         3'd0},
         '{OP_ENQUEUE, 3'd0, 2'd2, 16'h1234, 16'h00FF, 1'b1, STAT_QUEUED,         3'd0},
         '{OP_ENQUEUE, 3'd0, 2'd1, 16'hAAAA, 16'h5555, 1'b1, STAT_QUEUED,         3'd0},
         '{OP_SERVE,   3'd0, 2'd0, 16'h0000, 16'h0000, 1'b0, STAT_QUEUED,         3'd0},
         '{OP_SERVE,   3'd0, 2'd0, 16'h0000, 16'h0000, 1'b0, STAT_QUEUED,         3'd0},
         '{OP_SERVE,   3'd0, 2'd0, 16'h0000, 16'h0000, 1'b0, STAT_QUEUED,         3'd0},
         '{OP_SERVE,   3'd0, 2'd0, 16'h0000, 16'h0000, 1'b0, STAT_QUEUED,         3'd0},
         '{OP_SERVE,   3'd0, 2'd0, 16'h0000, 16'h0000, 1'b1, STAT_EMPTY,          3'd0},
         '{OP_ENQUEUE, 3'd5, 2'd1, 16'h0F0F, 16'hF0F0, 1'b1, STAT_DROPPED,        3'd0},
         '{OP_ENQUEUE, 3'd7, 2'd3, 16'hFFFF, 16'hFFFF, 1'b1, STAT_DROPPED,        3'd0},
         '{OP_SERVE,   3'd6, 2'd0, 16'h0000, 16'h0000, 1'b1, STAT_EMPTY,          3'd0},
         '{OP_CLOSE,   3'd7, 2'd0, 16'h0000, 16'h0000, 1'b1, STAT_ALREADY_CLOSED, 3'd0},
         '{OP_UNUSED,  3'd3, 2'd2, 16'hBEEF, 16'h1111, 1'b0, STAT_QUEUED,         3'd0},
         '{OP_ENQUEUE, 3'd4, 2'd3, 16'h5555, 16'h8000, 1'b1, STAT_QUEUED,         3'd0},
         '{OP_ENQUEUE, 3'd1, 2'd1, 16'h8001, 16'h7FFE, 1'b1, STAT_QUEUED,         3'd0},
         '{OP_ENQUEUE, 3'd0, 2'd2, 16'hC3C3, 16'h3C3C, 1'b1, STAT_QUEUED,         3'd0},
         '{OP_CLOSE,   3'd0, 2'd0, 16'h0000, 16'h0000, 1'b1, STAT_MOVED,          3'd1},
         '{OP_CLOSE,   3'd0, 2'd0, 16'h0000, 16'h0000, 1'b1, STAT_ALREADY_CLOSED, 3'd0},
         '{OP_ENQUEUE, 3'd0, 2'd1, 16'h0001, 16'h0001, 1'b1, STAT_DROPPED,        3'd0},
         '{OP_CLOSE,   3'd1, 2'd0, 16'h0000, 16'h0000, 1'b1, STAT_MOVED,          3'd2},
         '{OP_SERVE,   3'd2, 2'd0, 16'h0000, 16'h0000, 1'b0, STAT_QUEUED,         3'd0},
         '{OP_SERVE,   3'd2, 2'd0, 16'h0000, 16'h0000, 1'b0, STAT_QUEUED,         3'd0},
         '{OP_SERVE,   3'd4, 2'd0, 16'h0000, 16'h0000, 1'b0, STAT_QUEUED,         3'd0}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIRECTED_ROWS; row++) begin
         d.queue_index  = directed_plan[row].queue_index;
         d.priority_req = directed_plan[row].priority_req;
         d.customer_tag = directed_plan[row].customer_tag;
         d.item_count   = directed_plan[row].item_count;
         want = '0;
         want.status = directed_plan[row].want_status;
         want.data.target_queue = directed_plan[row].want_queue;
         offer_request(directed_plan[row].opc, d, directed_plan[row].typed, want);
      end

      // Random traffic alternates between filling, draining and balanced
      // stretches so that the pool both runs dry and empties out.
      k = 0;
      mix_left = 0;
      mix = MIX_BALANCED;
      while (k < RANDOM_ITEMS) begin
         if (mix_left == 0) begin
            mix = mix_type'($urandom_range(0, 2));
            mix_left = $urandom_range(30, 150);
         end
         mix_left--;
         d.customer_tag = TAG_BITS'($urandom);
         d.item_count   = ITEM_BITS'($urandom);
         d.priority_req = PRIO_BITS'($urandom_range(0, 3));
         roll = $urandom_range(0, 99);
         case (mix)
            MIX_FILL:  opc = (roll < 88) ? OP_ENQUEUE : (roll < 96) ? OP_SERVE : OP_CLOSE;
            MIX_DRAIN: opc = (roll < 12) ? OP_ENQUEUE : (roll < 96) ? OP_SERVE : OP_CLOSE;
            default:   opc = (roll < 47) ? OP_ENQUEUE : (roll < 94) ? OP_SERVE : OP_CLOSE;
         endcase
         if ($urandom_range(0, 39) == 0) opc = OP_UNUSED;
         if ($urandom_range(0, 9) == 0) begin
            d.queue_index = QUEUE_BITS'($urandom_range(0, 7));
         end else begin
            do qi = $urandom_range(0, NUM_QUEUES - 1); while (!queue_open[qi]);
            d.queue_index = QUEUE_BITS'(qi);
         end
         // Queues are closed for good, so successful closes are spread over
         // the run: the last open queue is reached two thirds of the way in.
         allowed_closed = DIRECTED_CLOSES + (3 * k) / RANDOM_ITEMS;
         if (opc == OP_CLOSE && d.queue_index < NUM_QUEUES && queue_open[d.queue_index] &&
             NUM_QUEUES - $countones(queue_open) >= allowed_closed)
            d.queue_index = QUEUE_BITS'($urandom_range(NUM_QUEUES, 7));
         offer_request(opc, d, 1'b0, '0);
         if (opc != OP_UNUSED) k++;
      end
      req_tvalid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d request items, %0d of them directed, and %0d result items.",
               requests_taken, DIRECTED_ROWS, results_seen);
      $display("Statuses: queued %0d, dropped %0d, pool full %0d, served %0d, empty %0d, %s",
               status_seen[STAT_QUEUED], status_seen[STAT_DROPPED],
               status_seen[STAT_POOL_FULL], status_seen[STAT_SERVED],
               status_seen[STAT_EMPTY],
               $sformatf("already closed %0d, last open busy %0d, no other open %0d, moved %0d.",
                         status_seen[STAT_ALREADY_CLOSED], status_seen[STAT_LAST_OPEN_BUSY],
                         status_seen[STAT_NO_OTHER_OPEN], status_seen[STAT_MOVED]));
      if (mismatch_count == 0) begin
         $display("multi_queue_priority_scheduler_unit verification clean");
      end else begin
         $display("multi_queue_priority_scheduler_unit verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/mqps_pkg.sv
hw/rtl/mqps_ptr_mem.sv
hw/rtl/mqps_entry_mem.sv
hw/rtl/mqps_free_stack.sv
hw/rtl/mqps_ctrl.sv
hw/rtl/multi_queue_priority_scheduler_unit.sv
tb/tb_multi_queue_priority_scheduler_unit.sv
